// ----- sv/nibble_morse_keying_decoder_defines.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef NIBBLE_MORSE_KEYING_DECODER_DEFINES_SVH
`define NIBBLE_MORSE_KEYING_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NMKD_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define NMKD_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- sv/nmkd_pkg.sv -----
// Types, constants and code table helpers for the Morse keying decoder.
package nmkd_pkg;

   localparam int HeaderBytesDefault = 8;
   localparam int MaxResults         = 3;
   localparam int ResultCountW       = 2;

   localparam logic [2:0] OnesSat        = 3'd7;
   localparam logic [1:0] GapClose       = 2'd3;
   localparam logic [2:0] CodeLenMax     = 3'd4;
   localparam logic [2:0] CodeLenInvalid = 3'd5;
   localparam logic [2:0] RunDot         = 3'd1;
   localparam logic [2:0] RunDash        = 3'd3;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_SHORT = 2'd2
   } nmkd_kind_type;

   typedef struct packed {
      logic [2:0] ones_run;
      logic [1:0] zeros_run;
      logic [2:0] code_length;
      logic [3:0] code_pattern;
      logic       high_pending;
      logic [3:0] upper_nib;
   } nmkd_code_state_type;

   typedef struct packed {
      nmkd_kind_type kind;
      logic [7:0]    value;
      logic          last;
   } nmkd_result_type;

   // Turns the pending run of ones into a dot or a dash, or marks a full code invalid; other run lengths are dropped.
   function automatic nmkd_code_state_type nmkd_add_element(nmkd_code_state_type st);
      nmkd_code_state_type r;
      r = st;
      if (st.ones_run == RunDot || st.ones_run == RunDash) begin
         if (st.code_length < CodeLenMax) begin
            r.code_pattern = {st.code_pattern[2:0], (st.ones_run == RunDash)};
            r.code_length  = st.code_length + 3'd1;
         end else begin
            r.code_length = CodeLenInvalid;
         end
      end
      return r;
   endfunction

   // Returns {valid, nibble} for a finished code.
   function automatic logic [4:0] nmkd_code_nibble(logic [2:0] len, logic [3:0] pat);
      logic [4:0] r;
      r = '0;
      unique case (len)
         3'd1: r = {1'b1, pat};
         3'd2: r = {1'b1, 4'd2 + pat};
         3'd3: r = {1'b1, 4'd6 + pat};
         3'd4: begin
            if (pat <= 4'd1) begin
               r = {1'b1, 4'd14 + pat};
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/nmkd_bit_engine.sv -----
// Eight unrolled bit steps plus the end-of-message flush of the Morse code tracker.
module nmkd_bit_engine
   import nmkd_pkg::*;
(
   input  nmkd_code_state_type                    state_i,
   input  logic [7:0]                             data_i,
   input  logic [3:0]                             take_i,
   input  logic                                   flush_i,
   output nmkd_code_state_type                    state_o,
   output nmkd_result_type [MaxResults-1:0]       res_o,
   output logic [ResultCountW-1:0]                count_o
);

   always_comb begin
      nmkd_code_state_type     st;
      nmkd_result_type [MaxResults-1:0] res;
      logic [ResultCountW-1:0] n;
      logic                    do_close;
      logic [4:0]              nib;
      st  = state_i;
      res = '0;
      n   = '0;
      nib = '0;
      for (int i = 0; i < 9; i++) begin
         do_close = 1'b0;
         if (i < 8) begin
            if (4'(i) < take_i) begin
               if (data_i[7 - i]) begin
                  st.zeros_run = '0;
                  if (st.ones_run < OnesSat) begin
                     st.ones_run = st.ones_run + 3'd1;
                  end
               end else begin
                  if (st.ones_run != '0) begin
                     st = nmkd_add_element(st);
                     st.ones_run = '0;
                  end
                  if (st.zeros_run < GapClose) begin
                     st.zeros_run = st.zeros_run + 2'd1;
                     do_close = (st.zeros_run == GapClose);
                  end
               end
            end
         end else if (flush_i) begin
            // End of message: a pending run becomes an element and the code closes.
            if (st.ones_run != '0) begin
               st = nmkd_add_element(st);
            end
            do_close = 1'b1;
         end
         if (do_close) begin
            nib = nmkd_code_nibble(st.code_length, st.code_pattern);
            st.code_length  = '0;
            st.code_pattern = '0;
            if (nib[4]) begin
               if (!st.high_pending) begin
                  st.upper_nib    = nib[3:0];
                  st.high_pending = 1'b1;
               end else begin
                  if (n < ResultCountW'(MaxResults)) begin
                     res[n].kind  = KIND_BYTE;
                     res[n].value = {st.upper_nib, nib[3:0]};
                     res[n].last  = 1'b0;
                     n = n + 1'b1;
                  end
                  st.high_pending = 1'b0;
               end
            end
         end
      end
      state_o = st;
      res_o   = res;
      count_o = n;
   end

endmodule

// ----- sv/nibble_morse_keying_decoder.sv -----
// Top level of the nibble Morse keying decoder.
// Each request transaction carries one message byte: the first HEADER_BYTES bytes form a
// little-endian bit count, later bytes are keyed bits, MSB first, and the byte flagged last
// closes the message with a status. A byte is decoded in the cycle it is accepted and its
// zero to three results go into a three-entry result buffer that drains one result per
// cycle while rsp_ready is high. A new byte is taken in every cycle while rsp_ready is
// high and each byte yields at most one result; after a byte with more, the request side
// waits until its last result is popped, since the single result port sets the rate.
// Header bytes yield no result but the status of a last byte, and stream at one per cycle.
`include "nibble_morse_keying_decoder_defines.svh"

module nibble_morse_keying_decoder
   import nmkd_pkg::*;
#(
   parameter int HEADER_BYTES = HeaderBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_value,
   output logic       rsp_last_of_run
);

   localparam int RemW = 8 * HEADER_BYTES;
   localparam int HcW  = $clog2(HEADER_BYTES + 1);
   localparam logic [HcW-1:0] HeaderFull = HcW'(HEADER_BYTES);

   logic [HcW-1:0]           header_count_ff, header_count_in;
   logic [RemW-1:0]          remaining_ff, remaining_in;
   nmkd_code_state_type      code_ff, code_in;
   nmkd_result_type [MaxResults-1:0] buf_ff, buf_in;
   logic [ResultCountW-1:0]  cnt_ff, cnt_in;

   logic                     accept, pop, header_done, header_ends, flush;
   logic [3:0]               take;
   nmkd_code_state_type      eng_state;
   nmkd_result_type [MaxResults-1:0] eng_res;
   logic [ResultCountW-1:0]  eng_count;

   assign accept      = req_valid && req_ready;
   assign pop         = rsp_valid && rsp_ready;
   assign header_done = (header_count_ff == HeaderFull);
   assign header_ends = header_done || (header_count_ff == HeaderFull - 1'b1);
   assign flush       = req_last_byte && header_ends;

   always_comb begin
      take = 4'd0;
      if (header_done) begin
         take = (|remaining_ff[RemW-1:3]) ? 4'd8 : {1'b0, remaining_ff[2:0]};
      end
   end

   nmkd_bit_engine u_engine (
      .state_i (code_ff),
      .data_i  (req_data_byte),
      .take_i  (take),
      .flush_i (flush),
      .state_o (eng_state),
      .res_o   (eng_res),
      .count_o (eng_count)
   );

   always_comb begin
      header_count_in = header_count_ff;
      remaining_in    = remaining_ff;
      code_in         = code_ff;
      if (accept) begin
         if (!header_done) begin
            header_count_in = header_count_ff + 1'b1;
            for (int b = 0; b < HEADER_BYTES; b++) begin
               if (header_count_ff == HcW'(b)) begin
                  remaining_in[8*b +: 8] = req_data_byte;
               end
            end
         end else begin
            remaining_in = remaining_ff - RemW'(take);
         end
         code_in = eng_state;
         if (req_last_byte) begin
            header_count_in = '0;
            remaining_in    = '0;
            code_in         = '0;
         end
      end
   end

   // Result buffer: loaded whole when a transaction is accepted, else shifted on a pop.
   always_comb begin
      logic [ResultCountW-1:0] n;
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      n      = eng_count;
      if (accept) begin
         buf_in = eng_res;
         if (req_last_byte && n < ResultCountW'(MaxResults)) begin
            buf_in[n].kind  = header_ends ? KIND_DONE : KIND_SHORT;
            buf_in[n].value = '0;
            buf_in[n].last  = 1'b0;
            n = n + 1'b1;
         end
         if (n != '0) begin
            buf_in[n - 1'b1].last = 1'b1;
         end
         cnt_in = n;
      end else if (pop) begin
         for (int k = 0; k < MaxResults - 1; k++) begin
            buf_in[k] = buf_ff[k + 1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= '0;
         remaining_ff    <= '0;
         code_ff         <= '0;
         cnt_ff          <= '0;
      end else begin
         header_count_ff <= header_count_in;
         remaining_ff    <= remaining_in;
         code_ff         <= code_in;
         cnt_ff          <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign req_ready       = (cnt_ff == '0) || (cnt_ff == ResultCountW'(1) && rsp_ready);
   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_result_kind = buf_ff[0].kind;
   assign rsp_value       = buf_ff[0].value;
   assign rsp_last_of_run = buf_ff[0].last;

   `NMKD_ASSERT_NEXT(a_header_silent, clock, reset, accept && !req_last_byte && !header_done, cnt_ff == '0, "header byte produced a result")
   `NMKD_ASSERT_NEXT(a_last_resets, clock, reset, accept && req_last_byte, header_count_ff == '0 && remaining_ff == '0 && code_ff == '0, "state not cleared after last byte")
   `NMKD_ASSERT_NOW(a_last_flag_tail, clock, reset, cnt_ff > ResultCountW'(1), !buf_ff[0].last, "last_of_run set before the final result")

endmodule

// ----- tb/sv/nibble_morse_keying_decoder_tb.sv -----
// Self-checking testbench for the nibble Morse keying decoder.
module nibble_morse_keying_decoder_tb;
   import nmkd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR           = HeaderBytesDefault;
   localparam int STALL_LIMIT   = 400;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_END    = 300;
   localparam int STEADY_ITEMS  = 50;
   localparam int REPORT_MAX    = 10;

   localparam logic [2:0] DOT_RUN       = 3'd1;
   localparam logic [2:0] DASH_RUN      = 3'd3;
   localparam logic [2:0] RUN_SAT       = 3'd7;
   localparam logic [1:0] GAP_CLOSE     = 2'd3;
   localparam logic [2:0] MAX_ELEMS     = 3'd4;
   localparam logic [2:0] CODE_OVERFLOW = 3'd5;
   localparam int         GAP_BITS      = int'(GAP_CLOSE);
   // Four-element codes start at this nibble in the alphabet.
   localparam int FOUR_ELEM_BASE = 14;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_value;
   logic       rsp_last_of_run;

   nibble_morse_keying_decoder #(.HEADER_BYTES(HDR)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_value       (rsp_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #2 clock = ~clock;

   // Decoder state as predicted.
   int          hdr_taken;
   logic [63:0] bit_limit;
   logic [63:0] bits_used;
   logic [2:0]  mark_run;
   logic [1:0]  space_run;
   logic [2:0]  elem_count;
   logic [3:0]  elem_bits;
   logic        pair_waiting;
   logic [3:0]  pair_high;

   nmkd_result_type step_results[$];
   nmkd_result_type expected_results[$];
   bit              key_bits[$];

   bit idle_on = 1'b0;
   int items_sent = 0;
   int mismatches = 0;
   int rsp_hold = 0;
   int quiet_cycles = 0;

   function void clear_decoder();
      hdr_taken    = 0;
      bit_limit    = '0;
      bits_used    = '0;
      mark_run     = '0;
      space_run    = '0;
      elem_count   = '0;
      elem_bits    = '0;
      pair_waiting = 1'b0;
      pair_high    = '0;
   endfunction

   function void post_result(nmkd_kind_type k, logic [7:0] v);
      nmkd_result_type r;
      r.kind  = k;
      r.value = v;
      r.last  = 1'b0;
      step_results = {step_results, r};
   endfunction

   function void add_mark();
      if (mark_run == DOT_RUN || mark_run == DASH_RUN) begin
         if (elem_count < MAX_ELEMS) begin
            elem_bits  = {elem_bits[2:0], mark_run == DASH_RUN};
            elem_count = elem_count + 3'd1;
         end else begin
            elem_count = CODE_OVERFLOW;
         end
      end
   endfunction

   function void finish_code();
      int nib;
      nib = -1;
      if (elem_count >= 1 && elem_count <= 3) begin
         nib = (1 << elem_count) - 2 + elem_bits;
      end else if (elem_count == MAX_ELEMS && elem_bits <= 1) begin
         nib = FOUR_ELEM_BASE + elem_bits;
      end
      elem_count = '0;
      elem_bits  = '0;
      if (nib >= 0) begin
         if (!pair_waiting) begin
            pair_high    = 4'(nib);
            pair_waiting = 1'b1;
         end else begin
            post_result(KIND_BYTE, {pair_high, 4'(nib)});
            pair_waiting = 1'b0;
         end
      end
   endfunction

   function void key_bit(bit b);
      if (b) begin
         space_run = '0;
         if (mark_run < RUN_SAT) mark_run = mark_run + 3'd1;
      end else begin
         if (mark_run != 0) begin
            add_mark();
            mark_run = '0;
         end
         if (space_run < GAP_CLOSE) begin
            space_run = space_run + 2'd1;
            if (space_run == GAP_CLOSE) finish_code();
         end
      end
   endfunction

   // Works out the results of one byte and queues them as expected.
   function void decode_byte(logic [7:0] b, logic lst);
      bit short_msg;
      step_results.delete();
      if (hdr_taken < HDR) begin
         bit_limit = bit_limit | (64'(b) << (8 * hdr_taken));
         hdr_taken++;
      end else begin
         for (int j = 7; j >= 0; j--) begin
            if (bits_used >= bit_limit) break;
            key_bit(b[j]);
            bits_used = bits_used + 64'd1;
         end
      end
      if (lst) begin
         short_msg = hdr_taken < HDR;
         if (!short_msg) begin
            if (mark_run != 0) add_mark();
            finish_code();
         end
         post_result(short_msg ? KIND_SHORT : KIND_DONE, 8'h00);
         clear_decoder();
      end
      if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) expected_results = {expected_results, step_results[i]};
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic lst);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      decode_byte(b, lst);
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sends the header and the keyed bits packed MSB first; bits past the stream are random.
   task automatic send_message(input logic [63:0] bit_len, input int data_bytes);
      logic [7:0] b;
      for (int i = 0; i < HDR; i++) begin
         send_byte(bit_len[8 * i +: 8], (data_bytes == 0) && (i == HDR - 1));
      end
      for (int i = 0; i < data_bytes; i++) begin
         for (int j = 0; j < 8; j++) begin
            b[7 - j] = (8 * i + j < key_bits.size()) ? key_bits[8 * i + j]
                                                    : 1'($urandom_range(0, 1));
         end
         send_byte(b, i == data_bytes - 1);
      end
      key_bits.delete();
   endtask

   task automatic send_short_message();
      int n;
      n = $urandom_range(1, HDR - 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
   endtask

   function void add_bits(bit v, int n);
      for (int i = 0; i < n; i++) key_bits = {key_bits, v};
   endfunction

   // Elements are split by one or two zeros, and the code ends with the given gap.
   function void add_code(string s, int gap);
      for (int i = 0; i < s.len(); i++) begin
         if (i != 0) add_bits(1'b0, $urandom_range(1, 2));
         add_bits(1'b1, (s[i] == "-") ? int'(DASH_RUN) : int'(DOT_RUN));
      end
      add_bits(1'b0, gap);
   endfunction

   function string code_symbols(int nib);
      case (nib)
         0:  return ".";
         1:  return "-";
         2:  return "..";
         3:  return ".-";
         4:  return "-.";
         5:  return "--";
         6:  return "...";
         7:  return "..-";
         8:  return ".-.";
         9:  return ".--";
         10: return "-..";
         11: return "-.-";
         12: return "--.";
         13: return "---";
         14: return "....";
         default: return "...-";
      endcase
   endfunction

   function string random_code(int len);
      string s;
      s = "";
      for (int i = 0; i < len; i++) s = {s, ($urandom_range(0, 1) != 0) ? "-" : "."};
      return s;
   endfunction

   // A message of valid codes with occasional broken ones and odd header counts.
   task automatic send_keyed_message();
      int          nibbles;
      int          gap;
      int          nbytes;
      logic [63:0] bit_len;
      nibbles = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) add_bits(1'b0, $urandom_range(1, 4));
      for (int n = 0; n < nibbles; n++) begin
         if (n == nibbles - 1 && $urandom_range(0, 1) != 0) begin
            gap = 0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : GAP_BITS;
         end
         case ($urandom_range(0, 11))
            0: add_code(random_code(5), gap);
            1: add_code(random_code(4), gap);
            2: begin
               add_bits(1'b1, ($urandom_range(0, 1) != 0) ? 2 : $urandom_range(4, 9));
               add_bits(1'b0, gap);
            end
            default: add_code(code_symbols($urandom_range(0, 15)), gap);
         endcase
      end
      case ($urandom_range(0, 7))
         0: bit_len = 64'(key_bits.size() - $urandom_range(0, key_bits.size()));
         1: bit_len = 64'(key_bits.size() + $urandom_range(1, 24));
         2: bit_len = {32'($urandom), 32'($urandom)};
         default: bit_len = 64'(key_bits.size());
      endcase
      nbytes = (key_bits.size() + 7) / 8;
      if ($urandom_range(0, 3) == 0) nbytes += $urandom_range(1, 2);
      send_message(bit_len, nbytes);
   endtask

   task automatic send_noise_message();
      int n;
      n = $urandom_range(0, 48);
      for (int i = 0; i < n; i++) key_bits = {key_bits, 1'($urandom_range(0, 1))};
      send_message(($urandom_range(0, 1) != 0) ? 64'(n) : 64'($urandom_range(0, 64)),
                   (n + 7) / 8);
   endtask

   task automatic test_directed_cases();
      // Message that ends inside its header, with both byte extremes.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // Leading zeros close an empty code.
      add_bits(1'b0, 3);
      add_code(".", GAP_BITS);
      add_code("-", GAP_BITS);
      // A long gap closes only once.
      add_bits(1'b0, 2);
      add_code(".....", GAP_BITS);
      add_bits(1'b1, 2);
      add_bits(1'b0, GAP_BITS);
      add_bits(1'b1, 8);
      add_bits(1'b0, GAP_BITS);
      add_code("-...", GAP_BITS);
      add_code("...-", GAP_BITS);
      add_code("....", GAP_BITS);
      add_code("..", GAP_BITS);
      // The final dash is still open when the message ends.
      add_code("-", 0);
      send_message(64'(key_bits.size()), (key_bits.size() + 7) / 8 + 1);
   endtask

   task automatic test_random_messages();
      while (items_sent < RANDOM_END) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 19))
            0, 1, 2:    send_noise_message();
            3, 4:       send_short_message();
            5, 6: begin
               for (int i = 0; i < $urandom_range(8, 32); i++) begin
                  key_bits = {key_bits, 1'($urandom_range(0, 1))};
               end
               send_message({32'($urandom), 32'($urandom)}, $urandom_range(1, 4));
            end
            default:    send_keyed_message();
         endcase
      end
   endtask

   task automatic test_unbroken_stream();
      int stop_at;
      idle_on = 1'b0;
      stop_at = items_sent + STEADY_ITEMS;
      while (items_sent < stop_at) send_keyed_message();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (mismatches < REPORT_MAX) begin
                  $display("unexpected result: kind %0d value %02h last %0b",
                           rsp_result_kind, rsp_value, rsp_last_of_run);
               end
               mismatches++;
            end else begin
               if (rsp_result_kind !== expected_results[0].kind ||
                   rsp_value !== expected_results[0].value ||
                   rsp_last_of_run !== expected_results[0].last) begin
                  if (mismatches < REPORT_MAX) begin
                     $display("result mismatch: kind %0d/%0d value %02h/%02h last %0b/%0b",
                              expected_results[0].kind, rsp_result_kind,
                              expected_results[0].value, rsp_value,
                              expected_results[0].last, rsp_last_of_run);
                  end
                  mismatches++;
               end
               void'(expected_results.pop_front());
            end
         end
         if (idle_on && rsp_hold == 0 && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(1, 16);
         end
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Ends the run when work is outstanding but no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else if (req_valid || expected_results.size() != 0) begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      clear_decoder();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;
      test_directed_cases();
      test_random_messages();
      test_unbroken_stream();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/nmkd_pkg.sv
sv/nmkd_bit_engine.sv
sv/nibble_morse_keying_decoder.sv
tb/sv/nibble_morse_keying_decoder_tb.sv
